// File: rtl/core/dcc_pkg.sv
// shared types and constants for the dcc track signal decoder
// no dependencies; imported by every module of the block
`default_nettype none

package dcc_pkg;

  // default sizing
  localparam int unsigned MaxFrameBytesDefault = 6;
  localparam int unsigned RunCountBitsDefault  = 16;

  // field widths
  localparam int unsigned BaseW      = 15;
  localparam int unsigned PreambleW  = 8;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 15;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned FrameDataW = 48;
  localparam int unsigned FrameLenW  = 3;
  localparam int unsigned KindW      = 3;
  localparam int unsigned HalfBitsN  = 16;
  localparam int unsigned FrameAccW  = 64;
  localparam int unsigned InDataW    = 8;
  localparam int unsigned OutDataW   = 64;

  // reset values of the configuration registers
  localparam logic [BaseW-1:0]     BaseResetVal     = 15'd58;
  localparam logic [PreambleW-1:0] PreambleResetVal = 8'd22;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_BASE_HALF = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_PREAMBLE  = 1'b1;

  typedef enum logic [1:0] {
    HALF_ZERO    = 2'd0,
    HALF_ONE     = 2'd1,
    HALF_UNKNOWN = 2'd2
  } half_kind_e;

  typedef enum logic [KindW-1:0] {
    EV_PREAMBLE  = 3'd0,
    EV_START     = 3'd1,
    EV_BYTE      = 3'd2,
    EV_BAD_BYTE  = 3'd3,
    EV_FRAME_END = 3'd4
  } event_kind_e;

  typedef struct packed {
    logic       valid;
    half_kind_e kind;
  } half_t;

  typedef struct packed {
    event_kind_e            kind;
    logic [ByteW-1:0]       byte_value;
    logic [FrameDataW-1:0]  frame_data;
    logic [FrameLenW-1:0]   frame_length;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/dcc_run_classifier.sv
// run length counter and half-period classifier
// depends on dcc_pkg
`default_nettype none

module dcc_run_classifier #(
  parameter int unsigned RUN_COUNT_BITS = dcc_pkg::RunCountBitsDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     accept_i,
  input  wire logic                     level_i,
  input  wire logic [dcc_pkg::BaseW-1:0] base_i,
  output dcc_pkg::half_t                half_o
);
  import dcc_pkg::*;

  localparam int unsigned CmpW = (RUN_COUNT_BITS > BaseW + 1) ? RUN_COUNT_BITS : BaseW + 1;
  localparam logic [RUN_COUNT_BITS-1:0] RunMax = '1;
  localparam logic [RUN_COUNT_BITS-1:0] RunOne = RUN_COUNT_BITS'(1);

  logic                      level_known_q, level_known_d;
  logic                      last_level_q, last_level_d;
  logic [RUN_COUNT_BITS-1:0] run_q, run_d;
  logic [CmpW-1:0]           run_ext, base_ext, twice_ext;

  assign run_ext   = CmpW'(run_q);
  assign base_ext  = CmpW'(base_i);
  assign twice_ext = CmpW'({base_i, 1'b0});

  always_comb begin
    level_known_d = level_known_q;
    last_level_d  = last_level_q;
    run_d         = run_q;
    half_o.valid  = 1'b0;
    half_o.kind   = HALF_UNKNOWN;
    if (accept_i) begin
      level_known_d = 1'b1;
      if (!level_known_q) begin
        // first sample opens a run of one
        last_level_d = level_i;
        run_d        = RunOne;
      end else if (level_i == last_level_q) begin
        if (run_q != RunMax) begin
          run_d = run_q + RunOne;
        end
      end else begin
        last_level_d = level_i;
        run_d        = RunOne;
        if (run_ext == base_ext) begin
          half_o.valid = 1'b1;
          half_o.kind  = HALF_ONE;
        end else if (run_ext >= twice_ext) begin
          half_o.valid = 1'b1;
          half_o.kind  = HALF_ZERO;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_known_q <= 1'b0;
      last_level_q  <= 1'b0;
      run_q         <= '0;
    end else begin
      level_known_q <= level_known_d;
      last_level_q  <= last_level_d;
      run_q         <= run_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dcc_framer.sv
// framing machine: preamble, separator and byte retrieval, frame byte store
// depends on dcc_pkg
`default_nettype none

module dcc_framer #(
  parameter int unsigned MAX_FRAME_BYTES = dcc_pkg::MaxFrameBytesDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire dcc_pkg::half_t               half_i,
  input  wire logic [dcc_pkg::PreambleW-1:0] preamble_i,
  output logic                              res_valid_o,
  output dcc_pkg::result_t                  res_o
);
  import dcc_pkg::*;

  localparam int unsigned SlotW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [SlotW-1:0] SlotMax = SlotW'(MAX_FRAME_BYTES);

  typedef enum logic [1:0] {
    PH_PREAMBLE,
    PH_SEPARATOR,
    PH_BYTE
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [PreambleW-1:0]   ones_q, ones_d, ones_inc;
  half_kind_e             prior_q, prior_d;
  logic [3:0]             hcnt_q, hcnt_d;
  logic [SlotW-1:0]       slot_q, slot_d;
  logic [HalfBitsN-1:0]   hbits_q, hbits_new;
  logic [ByteW-1:0]       store_q [MAX_FRAME_BYTES];
  logic                   hbit_we, store_we, pair_bad;
  logic [ByteW-1:0]       byte_dec;
  logic [FrameAccW-1:0]   frame_acc;
  logic [SlotW+FrameLenW-1:0] slot_ext;

  assign ones_inc = (ones_q != '1) ? ones_q + PreambleW'(1) : ones_q;
  assign slot_ext = {{FrameLenW{1'b0}}, slot_q};

  // half-period pairs, msb first, with the incoming half in place
  always_comb begin
    hbits_new         = hbits_q;
    hbits_new[hcnt_q] = (half_i.kind == HALF_ONE);
    pair_bad          = 1'b0;
    byte_dec          = '0;
    for (int i = 0; i < 8; i++) begin
      pair_bad        = pair_bad | (hbits_new[2*i] ^ hbits_new[2*i+1]);
      byte_dec[7 - i] = hbits_new[2*i];
    end
  end

  always_comb begin
    frame_acc = '0;
    for (int i = 0; i < MAX_FRAME_BYTES; i++) begin
      if (SlotW'(i) < slot_q) begin
        frame_acc[8*i +: 8] = store_q[i];
      end
    end
  end

  always_comb begin
    phase_d            = phase_q;
    ones_d             = ones_q;
    prior_d            = prior_q;
    hcnt_d             = hcnt_q;
    slot_d             = slot_q;
    hbit_we            = 1'b0;
    store_we           = 1'b0;
    res_valid_o        = 1'b0;
    res_o.kind         = EV_PREAMBLE;
    res_o.byte_value   = '0;
    res_o.frame_data   = '0;
    res_o.frame_length = '0;
    if (half_i.valid) begin
      case (phase_q)
        PH_PREAMBLE: begin
          if (half_i.kind == HALF_ONE) begin
            ones_d = ones_inc;
            if (ones_inc >= preamble_i) begin
              ones_d      = '0;
              slot_d      = '0;
              prior_d     = HALF_UNKNOWN;
              phase_d     = PH_SEPARATOR;
              res_valid_o = 1'b1;
              res_o.kind  = EV_PREAMBLE;
            end
          end else begin
            ones_d = '0;
          end
        end
        PH_SEPARATOR: begin
          if (prior_q == HALF_UNKNOWN) begin
            prior_d = half_i.kind;
          end else if (prior_q == HALF_ZERO && half_i.kind == HALF_ZERO) begin
            hcnt_d      = '0;
            ones_d      = '0;
            phase_d     = PH_BYTE;
            res_valid_o = 1'b1;
            res_o.kind  = EV_START;
          end else if (prior_q == HALF_ONE && half_i.kind == HALF_ONE) begin
            hcnt_d             = '0;
            ones_d             = '0;
            phase_d            = PH_PREAMBLE;
            res_valid_o        = 1'b1;
            res_o.kind         = EV_FRAME_END;
            res_o.frame_data   = frame_acc[FrameDataW-1:0];
            res_o.frame_length = slot_ext[FrameLenW-1:0];
          end
        end
        PH_BYTE: begin
          hbit_we = 1'b1;
          hcnt_d  = hcnt_q + 4'd1;
          if (hcnt_q == 4'd15) begin
            hcnt_d      = '0;
            res_valid_o = 1'b1;
            if (pair_bad) begin
              ones_d     = '0;
              phase_d    = PH_PREAMBLE;
              res_o.kind = EV_BAD_BYTE;
            end else begin
              if (slot_q < SlotMax) begin
                store_we = 1'b1;
                slot_d   = slot_q + SlotW'(1);
              end
              prior_d          = HALF_UNKNOWN;
              phase_d          = PH_SEPARATOR;
              res_o.kind       = EV_BYTE;
              res_o.byte_value = byte_dec;
            end
          end
        end
        default: begin
          phase_d = PH_PREAMBLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PREAMBLE;
      ones_q  <= '0;
      prior_q <= HALF_UNKNOWN;
      hcnt_q  <= '0;
      slot_q  <= '0;
    end else begin
      phase_q <= phase_d;
      ones_q  <= ones_d;
      prior_q <= prior_d;
      hcnt_q  <= hcnt_d;
      slot_q  <= slot_d;
    end
  end

  // half-period and byte stores, written before they are read
  always_ff @(posedge clk_i) begin
    if (hbit_we) begin
      hbits_q[hcnt_q] <= (half_i.kind == HALF_ONE);
    end
    for (int i = 0; i < MAX_FRAME_BYTES; i++) begin
      if (store_we && slot_q == SlotW'(i)) begin
        store_q[i] <= byte_dec;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dcc_out_buffer.sv
// result register with one skid entry between the decoder and the output stream
// depends on dcc_pkg
`default_nettype none

module dcc_out_buffer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire dcc_pkg::result_t res_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output dcc_pkg::result_t out_o
);
  import dcc_pkg::*;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    pop, load;

  assign pop         = out_valid_q & out_ready_i;
  assign load        = !out_valid_q || pop;
  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q  <= skid_valid_q | push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= skid_valid_q ? skid_q : res_i;
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

  // skid only holds an item behind a waiting output
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without output entry");

  // no push arrives while the skid entry is in use
  a_no_push_on_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("push into full buffer");

  // a stalled output with a new push parks the item in the skid entry
  a_stall_parks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && push_i) |=> skid_valid_q)
    else $error("item lost during stall");

  // a waiting skid entry moves up once the output is taken
  a_skid_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid entry not forwarded");

endmodule

`default_nettype wire

// File: rtl/core/dcc_track_signal_decoder.sv
// top level of the dcc track signal decoder: config registers, classifier,
// framer and output buffer; depends on dcc_pkg and the three submodules
//
//   channel   direction  handshake                         payload
//   s_axis    in         s_axis_tvalid_i / s_axis_tready_o  tdata[0] line_level
//   m_axis    out        m_axis_tvalid_o / m_axis_tready_i  tuser event_kind, tdata results
//   cfg       in         cfg_we_i (no handshake back)       cfg_idx_i, cfg_data_i
//
// one sample is taken per clock while s_axis_tready_o is high; a sample updates the run
// counter and the framing machine in the cycle it is accepted, and any result is registered
// at that edge, in the output register or, behind a stalled output, in the skid entry.
// the output side has a result register plus one skid entry: sampling stops only
// when both hold items, which takes two stalled results in a row.
// reset clears the run counter, the framing machine and the buffer valid bits;
// configuration returns to base 58 and preamble 22.
`default_nettype none

module dcc_track_signal_decoder #(
  parameter int unsigned MAX_FRAME_BYTES = dcc_pkg::MaxFrameBytesDefault,
  parameter int unsigned RUN_COUNT_BITS  = dcc_pkg::RunCountBitsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [dcc_pkg::InDataW-1:0]    s_axis_tdata_i,  // [0] line_level
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [dcc_pkg::OutDataW-1:0]        m_axis_tdata_o,  // [7:0] byte_value,
                                                               // [55:8] frame_data,
                                                               // [58:56] frame_length
  output logic [dcc_pkg::KindW-1:0]           m_axis_tuser_o,  // [2:0] event_kind
  input  wire logic                           cfg_we_i,
  input  wire logic [dcc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [dcc_pkg::CfgDataW-1:0]   cfg_data_i
);
  import dcc_pkg::*;

  logic [BaseW-1:0]     base_q;
  logic [PreambleW-1:0] preamble_q;
  logic                 accept;
  half_t                half;
  logic                 res_valid;
  result_t              res, out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= BaseResetVal;
      preamble_q <= PreambleResetVal;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASE_HALF: base_q     <= cfg_data_i[BaseW-1:0];
        REG_PREAMBLE:  preamble_q <= cfg_data_i[PreambleW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign accept = s_axis_tvalid_i & s_axis_tready_o;

  dcc_run_classifier #(
    .RUN_COUNT_BITS(RUN_COUNT_BITS)
  ) u_classifier (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .level_i  (s_axis_tdata_i[0]),
    .base_i   (base_q),
    .half_o   (half)
  );

  dcc_framer #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .half_i      (half),
    .preamble_i  (preamble_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dcc_out_buffer u_out_buffer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .res_i       (res),
    .ready_o     (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (out_res)
  );

  assign m_axis_tdata_o = {5'b0, out_res.frame_length, out_res.frame_data, out_res.byte_value};
  assign m_axis_tuser_o = out_res.kind;

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// testbench for dcc_track_signal_decoder: drives line samples over the input stream,
// predicts the framing events in step and checks every output item against them
// depends on dcc_pkg and the rtl of the block
`timescale 1ns / 100ps

module tb_top;
  import dcc_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned IdlePct    = 22;
  localparam int unsigned RandomSamples = 1400;
  localparam int unsigned SettleCycles  = 4;

  typedef enum logic [1:0] {
    SEEK_PREAMBLE,
    SEEK_SEPARATOR,
    READ_BYTE
  } framer_phase_e;

  // one directed step: a register write, or reps runs of amount samples each
  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [31:0]         amount;
    logic [7:0]          reps;
    logic                check;
    result_t             want;
  } plan_row_t;

  localparam int unsigned PlanRows = 35;

  // columns: is_cfg, reg_idx, amount, reps, check, want {kind, byte, frame data, length}
  // a checked row's result is the one caused by its first sample
  localparam plan_row_t DirectedPlan [PlanRows] = '{
    // reset values: a run of 58 is a one, and 22 ones find the preamble
    '{1'b0, REG_BASE_HALF, 32'd58,    8'd1,   1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd1,     8'd1,   1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b1, REG_BASE_HALF, 32'd1,     8'd1,   1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd1,     8'd20,  1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd2,     8'd1,   1'b1, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd2,     8'd1,   1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd1,     8'd1,   1'b1, '{EV_START,     8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd1,     8'd15,  1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd1,     8'd1,   1'b1, '{EV_BYTE,      8'hFF, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd1,     8'd1,   1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd2,     8'd1,   1'b1, '{EV_FRAME_END, 8'h00, 48'hFF, 3'd1}},
    // shortest base, longest preamble; unlike separator pair; mismatched pair
    '{1'b1, REG_BASE_HALF, 32'd1,     8'd1,   1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b1, REG_PREAMBLE,  32'd255,   8'd1,   1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd1,     8'd255, 1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd2,     8'd1,   1'b1, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd1,     8'd1,   1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd3,     8'd1,   1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd1,     8'd1,   1'b1, '{EV_START,     8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd2,     8'd1,   1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd2,     8'd14,  1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd2,     8'd1,   1'b1, '{EV_BAD_BYTE,  8'h00, 48'h0,  3'd0}},
    // preamble of a single one
    '{1'b1, REG_PREAMBLE,  32'd1,     8'd1,   1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd1,     8'd1,   1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd3,     8'd1,   1'b1, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd3,     8'd1,   1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd3,     8'd1,   1'b1, '{EV_START,     8'h00, 48'h0,  3'd0}},
    // preamble count of zero
    '{1'b1, REG_BASE_HALF, 32'd3,     8'd1,   1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b1, REG_PREAMBLE,  32'd0,     8'd1,   1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd3,     8'd15,  1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd4,     8'd1,   1'b1, '{EV_BYTE,      8'hFF, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd3,     8'd2,   1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd3,     8'd1,   1'b1, '{EV_FRAME_END, 8'h00, 48'hFF, 3'd1}},
    '{1'b0, REG_BASE_HALF, 32'd7,     8'd1,   1'b1, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    // base of zero: every finished run is a zero half-period
    '{1'b1, REG_BASE_HALF, 32'd0,     8'd1,   1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}},
    '{1'b0, REG_BASE_HALF, 32'd5,     8'd3,   1'b0, '{EV_PREAMBLE,  8'h00, 48'h0,  3'd0}}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [InDataW-1:0]   s_axis_tdata_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [OutDataW-1:0]  m_axis_tdata_o;
  logic [KindW-1:0]     m_axis_tuser_o;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  dcc_track_signal_decoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // [0] line_level
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [7:0] byte_value, [55:8] frame_data,
                                         // [58:56] frame_length
    .m_axis_tuser_o  (m_axis_tuser_o),   // [2:0] event_kind
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow of the decoder: configuration, run counter and framing machine
  logic [BaseW-1:0]      base_len = BaseResetVal;
  logic [PreambleW-1:0]  pre_need = PreambleResetVal;
  logic                  lvl_valid = 1'b0;
  logic                  lvl_prev = 1'b0;
  logic [15:0]           run_cnt = '0;
  framer_phase_e         phase = SEEK_PREAMBLE;
  logic [7:0]            ones_cnt = '0;
  half_kind_e            sep_prior = HALF_UNKNOWN;
  logic                  halves [HalfBitsN];
  logic [4:0]            half_cnt = '0;
  logic [2:0]            slot = '0;
  logic [ByteW-1:0]      frame_bytes [MaxFrameBytesDefault];

  result_t      expected_events [$];
  int unsigned  samples_sent = 0;
  int unsigned  failures = 0;
  int unsigned  cycle_count = 0;
  int unsigned  steady_lo = 0;
  int unsigned  steady_hi = 0;
  logic         line_now = 1'b0;
  bit           steady = 1'b0;

  function automatic void decode_sample(input logic lvl, output bit got, output result_t ev);
    bit               is_half;
    half_kind_e       hk;
    bit               bad;
    logic [ByteW-1:0] v;
    logic [47:0]      data;
    got = 1'b0;
    ev = '0;
    is_half = 1'b0;
    hk = HALF_UNKNOWN;
    if (!lvl_valid) begin
      lvl_valid = 1'b1;
      lvl_prev = lvl;
      run_cnt = '0;
    end
    if (lvl == lvl_prev) begin
      if (run_cnt != '1) run_cnt++;
    end else begin
      if (run_cnt == {1'b0, base_len}) begin
        is_half = 1'b1;
        hk = HALF_ONE;
      end else if ({1'b0, run_cnt} >= {1'b0, base_len, 1'b0}) begin
        is_half = 1'b1;
        hk = HALF_ZERO;
      end
      lvl_prev = lvl;
      run_cnt = 16'd1;
    end
    if (is_half) begin
      case (phase)
        SEEK_PREAMBLE: begin
          if (hk == HALF_ONE) begin
            if (ones_cnt != 8'hFF) ones_cnt++;
            if (ones_cnt >= pre_need) begin
              ones_cnt = '0;
              slot = '0;
              sep_prior = HALF_UNKNOWN;
              phase = SEEK_SEPARATOR;
              got = 1'b1;
              ev.kind = EV_PREAMBLE;
            end
          end else begin
            ones_cnt = '0;
          end
        end
        SEEK_SEPARATOR: begin
          if (sep_prior == HALF_UNKNOWN) begin
            sep_prior = hk;
          end else if (sep_prior == HALF_ZERO && hk == HALF_ZERO) begin
            half_cnt = '0;
            ones_cnt = '0;
            phase = READ_BYTE;
            got = 1'b1;
            ev.kind = EV_START;
          end else if (sep_prior == HALF_ONE && hk == HALF_ONE) begin
            data = '0;
            for (int i = 0; i < MaxFrameBytesDefault; i++) begin
              if (i < slot) data[8*i +: 8] = frame_bytes[i];
            end
            half_cnt = '0;
            ones_cnt = '0;
            phase = SEEK_PREAMBLE;
            got = 1'b1;
            ev.kind = EV_FRAME_END;
            ev.frame_data = data;
            ev.frame_length = slot;
          end
        end
        default: begin
          halves[half_cnt[3:0]] = (hk == HALF_ONE);
          half_cnt++;
          if (half_cnt >= HalfBitsN) begin
            bad = 1'b0;
            v = '0;
            // pairs taken msb first
            for (int i = 0; i < 8; i++) begin
              if (halves[2*i] != halves[2*i+1]) bad = 1'b1;
              v = {v[6:0], halves[2*i]};
            end
            half_cnt = '0;
            got = 1'b1;
            if (bad) begin
              ones_cnt = '0;
              phase = SEEK_PREAMBLE;
              ev.kind = EV_BAD_BYTE;
            end else begin
              if (slot < MaxFrameBytesDefault) begin
                frame_bytes[slot] = v;
                slot++;
              end
              sep_prior = HALF_UNKNOWN;
              phase = SEEK_SEPARATOR;
              ev.kind = EV_BYTE;
              ev.byte_value = v;
            end
          end
        end
      endcase
    end
  endfunction

  task automatic put_sample(input logic lvl, output bit got, output result_t ev);
    // no idling on either side inside the steady window
    steady = (samples_sent >= steady_lo) && (samples_sent < steady_hi);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {{(InDataW-1){1'b0}}, lvl};
    do @(posedge clk_i); while (!s_axis_tready_o);
    samples_sent++;
    decode_sample(lvl, got, ev);
  endtask

  // one run of the line at the opposite level; a checked run queues the typed result
  task automatic drive_run(input int unsigned len, input bit check = 1'b0,
                           input result_t want = '0);
    bit      got;
    bit      hit;
    result_t ev;
    hit = 1'b0;
    line_now = ~line_now;
    for (int unsigned k = 0; k < len; k++) begin
      put_sample(line_now, got, ev);
      if (got) begin
        hit = 1'b1;
        expected_events.push_back(check ? want : ev);
      end
    end
    if (check && !hit) expected_events.push_back(want);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_BASE_HALF) base_len = val[BaseW-1:0];
    else pre_need = val[PreambleW-1:0];
  endtask

  task automatic send_half(input bit one);
    int unsigned n;
    // ignored run of a length that is neither a one nor a zero
    if (base_len > 1 && $urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 2 * base_len - 2);
      if (n >= base_len) n++;
      drive_run(n);
    end
    if (base_len == 0) drive_run($urandom_range(1, 4));
    else if (one) drive_run(base_len);
    else drive_run(2 * base_len + $urandom_range(0, 3));
  endtask

  task automatic send_frame();
    int unsigned      n_pre;
    int unsigned      n_bytes;
    int               flaw;
    logic [ByteW-1:0] b;
    send_half(1'b0);
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) send_half(1'b1);
      send_half(1'b0);
    end
    n_pre = (pre_need == 0) ? 1 : pre_need;
    if ($urandom_range(0, 7) == 0) n_pre++;
    repeat (n_pre) send_half(1'b1);
    n_bytes = $urandom_range(0, 8);
    for (int i = 0; i < n_bytes; i++) begin
      // unlike first pair: the odd one is skipped
      if ($urandom_range(0, 5) == 0) begin
        send_half(1'b0);
        send_half(1'b1);
      end else begin
        send_half(1'b0);
      end
      send_half(1'b0);
      b = $urandom_range(0, 255);
      flaw = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 7)) : 8;
      for (int k = 7; k >= 0; k--) begin
        send_half(b[k]);
        send_half(b[k] ^ (k == flaw));
      end
      if (flaw < 8) return;
    end
    if ($urandom_range(0, 5) == 0) begin
      send_half(1'b1);
      send_half(1'b0);
    end else begin
      send_half(1'b1);
    end
    send_half(1'b1);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready_i <= steady || ($urandom_range(0, 99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    result_t exp_ev;
    result_t seen;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen.kind = event_kind_e'(m_axis_tuser_o);
      seen.byte_value = m_axis_tdata_o[7:0];
      seen.frame_data = m_axis_tdata_o[55:8];
      seen.frame_length = m_axis_tdata_o[58:56];
      if (expected_events.size() == 0) begin
        $error("unexpected item: event_kind %0d", seen.kind);
        failures++;
      end else begin
        exp_ev = expected_events.pop_front();
        if (seen.kind != exp_ev.kind) begin
          $error("event_kind: expected %0d, got %0d", exp_ev.kind, seen.kind);
          failures++;
        end
        if (seen.byte_value != exp_ev.byte_value) begin
          $error("byte_value: expected %0h, got %0h", exp_ev.byte_value, seen.byte_value);
          failures++;
        end
        if (seen.frame_data != exp_ev.frame_data) begin
          $error("frame_data: expected %0h, got %0h", exp_ev.frame_data, seen.frame_data);
          failures++;
        end
        if (seen.frame_length != exp_ev.frame_length) begin
          $error("frame_length: expected %0d, got %0d", exp_ev.frame_length,
                 seen.frame_length);
          failures++;
        end
      end
    end
  end

  initial begin
    int unsigned      sample_mark;
    int unsigned      pick;
    logic [BaseW-1:0] new_base;
    logic [7:0]       new_pre;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_BASE_HALF;
    cfg_data_i = '0;
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
    foreach (halves[i]) halves[i] = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedPlan[i]) begin
      if (DirectedPlan[i].is_cfg) begin
        write_reg(DirectedPlan[i].reg_idx, DirectedPlan[i].amount[CfgDataW-1:0]);
      end else begin
        for (int r = 0; r < DirectedPlan[i].reps; r++)
          drive_run(DirectedPlan[i].amount, DirectedPlan[i].check, DirectedPlan[i].want);
      end
    end

    sample_mark = samples_sent;
    steady_lo = sample_mark + 300;
    steady_hi = sample_mark + 900;
    while (samples_sent - sample_mark < RandomSamples) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) new_base = '0;
      else if (pick < 14) new_base = $urandom_range(1, 3);
      else if (pick < 19) new_base = $urandom_range(4, 9);
      else new_base = $urandom_range(10, 20);
      if (new_base != 0 && new_base <= 2 && $urandom_range(0, 9) == 0) new_pre = 8'hFF;
      else new_pre = $urandom_range(0, 6);
      if ($urandom_range(0, 1) == 1) begin
        write_reg(REG_BASE_HALF, CfgDataW'(new_base));
        write_reg(REG_PREAMBLE, CfgDataW'(new_pre));
      end else begin
        write_reg(REG_PREAMBLE, CfgDataW'(new_pre));
        write_reg(REG_BASE_HALF, CfgDataW'(new_base));
      end
      repeat ($urandom_range(2, 4)) begin
        if (samples_sent - sample_mark < RandomSamples) begin
          if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(10, 40)) drive_run($urandom_range(1, 2 * base_len + 3));
          end else begin
            send_frame();
          end
        end
      end
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/dcc_pkg.sv
rtl/core/dcc_run_classifier.sv
rtl/core/dcc_framer.sv
rtl/core/dcc_out_buffer.sv
rtl/core/dcc_track_signal_decoder.sv
sim/tb_top.sv
